// ===== hdl/masm_pkg.sv =====
`default_nettype none

package masm_pkg;

    localparam int MAX_DIM_DEF = 8;
    localparam int DATA_W      = 32;
    localparam int IDX_W       = 3;
    localparam int DIM_W       = 4;
    localparam int CFG_IDX_W   = 2;

    localparam logic [1:0] OP_LOAD_A  = 2'd0;
    localparam logic [1:0] OP_LOAD_B  = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_SUB = 2'd1;
    localparam logic [1:0] MODE_MUL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B     = 2'd3;

    typedef struct packed {
        logic             valid;
        logic             first_k;
        logic             last_k;
        logic             last;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } tag_t;

endpackage

`default_nettype wire

// ===== hdl/masm_ram.sv =====
`default_nettype none

module masm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/matrix_add_sub_mul_engine.sv =====
// Matrix add / subtract / multiply engine, signed Q16.16, saturating.
// Input channel (in_valid / in_stall): each transfer carries operation,
// row_index, col_index and element_value. Loads of A or B are taken one per
// cycle and write the A or B memory. A compute transfer starts a result run
// and in_stall stays high while the run's memory reads are issued.
// Output channel (out_valid / out_stall): one transfer per result element,
// row-major, last set on the final element.
// Add and subtract give one element per cycle while out_stall is low;
// multiply gives one element per inner_size operand pairs, read through the
// single read port of each memory that feeds one A and one B operand per
// cycle into the multiply-accumulate.
// A run issues rows_a * cols * (inner_size for multiply, else 1) read pairs.
// Configuration (cfg_we, cfg_index, cfg_data) is to be written by the user while idle; the block does not enforce it.
// Reset: configuration registers return to op_mode 0 and all dimensions 1; memory
// contents are undefined until loaded.
// While out_stall holds a pending result, the whole read pipeline freezes
// and nothing is lost; loads are still taken when no run is being issued.
`default_nettype none

module matrix_add_sub_mul_engine
    import masm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [1:0]           operation,
    input  wire logic [IDX_W-1:0]     row_index,
    input  wire logic [IDX_W-1:0]     col_index,
    input  wire logic [DATA_W-1:0]    element_value,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [IDX_W-1:0]          out_row,
    output logic [IDX_W-1:0]          out_col,
    output logic [DATA_W-1:0]         result_value,
    output logic                      last
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIM    = (MAX_DIM < 8) ? MAX_DIM : 8;
    localparam int FULL_W = ADDR_W + 8;

    function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                    input logic [IDX_W-1:0] c);
        logic [FULL_W-1:0] full;
        full = FULL_W'(r) * FULL_W'(MAX_DIM) + FULL_W'(c);
        return full[ADDR_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] dim_last(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] e;
        if (v == '0)
        begin
            e = DIM_W'(1);
        end
        else if (v > DIM_W'(LIM))
        begin
            e = DIM_W'(LIM);
        end
        else
        begin
            e = v;
        end
        e = e - DIM_W'(1);
        return e[IDX_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] sat64(input logic [63:0] v);
        if ((&v[63:DATA_W-1]) || !(|v[63:DATA_W-1]))
        begin
            return v[DATA_W-1:0];
        end
        else if (v[63])
        begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

    logic [1:0]       op_mode_reg;
    logic [DIM_W-1:0] rows_a_reg;
    logic [DIM_W-1:0] inner_size_reg;
    logic [DIM_W-1:0] cols_b_reg;

    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] cnt_i_reg, cnt_i_next;
    logic [IDX_W-1:0] cnt_j_reg, cnt_j_next;
    logic [IDX_W-1:0] cnt_k_reg, cnt_k_next;

    tag_t tag1_reg, tag1_next;
    tag_t tag2_reg;
    tag_t tag3_reg;

    logic [63:0]       prod_reg, prod_next;
    logic [DATA_W-1:0] term_reg, term_next;
    logic [DATA_W-1:0] acc_reg, acc_next;

    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  out_row_reg;
    logic [IDX_W-1:0]  out_col_reg;
    logic [DATA_W-1:0] result_reg;
    logic              last_reg;

    logic              advance;
    logic              in_xfer;
    logic              in_range;
    logic              start;
    logic              issue;
    logic              is_mul;
    logic [IDX_W-1:0]  i_last, j_last, k_last;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] a_raddr, b_raddr;
    logic              a_we, b_we;
    logic [DATA_W-1:0] a_rdata, b_rdata;
    logic [DATA_W:0]   sum2;
    logic [63:0]       round3;
    logic [DATA_W:0]   sum4;
    logic [DATA_W-1:0] acc_val;
    logic              load_out;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = busy_reg;
    assign in_xfer  = in_valid && !busy_reg;
    assign in_range = (int'(row_index) < MAX_DIM) && (int'(col_index) < MAX_DIM);
    assign waddr    = elem_addr(row_index, col_index);
    assign a_we     = in_xfer && (operation == OP_LOAD_A) && in_range;
    assign b_we     = in_xfer && (operation == OP_LOAD_B) && in_range;
    assign start    = in_xfer && (operation == OP_COMPUTE)
                      && ((op_mode_reg == MODE_ADD) || (op_mode_reg == MODE_SUB)
                          || (op_mode_reg == MODE_MUL));
    assign issue    = busy_reg && advance;
    assign is_mul   = (op_mode_reg == MODE_MUL);

    assign i_last = dim_last(rows_a_reg);
    assign j_last = is_mul ? dim_last(cols_b_reg) : dim_last(inner_size_reg);
    assign k_last = is_mul ? dim_last(inner_size_reg) : '0;

    assign a_raddr = is_mul ? elem_addr(cnt_i_reg, cnt_k_reg) : elem_addr(cnt_i_reg, cnt_j_reg);
    assign b_raddr = is_mul ? elem_addr(cnt_k_reg, cnt_j_reg) : elem_addr(cnt_i_reg, cnt_j_reg);

    masm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (waddr),
        .wdata (element_value),
        .re    (issue),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    masm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .clk   (clk),
        .we    (b_we),
        .waddr (waddr),
        .wdata (element_value),
        .re    (issue),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // issue counters, k innermost
    always_comb
    begin
        busy_next  = busy_reg;
        cnt_i_next = cnt_i_reg;
        cnt_j_next = cnt_j_reg;
        cnt_k_next = cnt_k_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_i_next = '0;
            cnt_j_next = '0;
            cnt_k_next = '0;
        end
        else if (issue)
        begin
            if (cnt_k_reg != k_last)
            begin
                cnt_k_next = cnt_k_reg + IDX_W'(1);
            end
            else
            begin
                cnt_k_next = '0;
                if (cnt_j_reg != j_last)
                begin
                    cnt_j_next = cnt_j_reg + IDX_W'(1);
                end
                else
                begin
                    cnt_j_next = '0;
                    if (cnt_i_reg != i_last)
                    begin
                        cnt_i_next = cnt_i_reg + IDX_W'(1);
                    end
                    else
                    begin
                        busy_next = 1'b0;
                    end
                end
            end
        end
    end

    always_comb
    begin
        tag1_next         = '0;
        tag1_next.valid   = issue;
        tag1_next.first_k = (cnt_k_reg == '0);
        tag1_next.last_k  = (cnt_k_reg == k_last);
        tag1_next.last    = (cnt_k_reg == k_last) && (cnt_j_reg == j_last)
                            && (cnt_i_reg == i_last);
        tag1_next.row     = cnt_i_reg;
        tag1_next.col     = cnt_j_reg;
    end

    // product or sum, then round (multiply only) and saturate, then accumulate
    always_comb
    begin
        if (op_mode_reg == MODE_SUB)
        begin
            sum2 = {a_rdata[DATA_W-1], a_rdata} - {b_rdata[DATA_W-1], b_rdata};
        end
        else
        begin
            sum2 = {a_rdata[DATA_W-1], a_rdata} + {b_rdata[DATA_W-1], b_rdata};
        end
        if (is_mul)
        begin
            prod_next = $signed(a_rdata) * $signed(b_rdata);
        end
        else
        begin
            prod_next = {{(64-DATA_W-1){sum2[DATA_W]}}, sum2};
        end

        round3 = $signed(prod_reg + 64'd32768) >>> 16;
        term_next = is_mul ? sat64(round3) : sat64(prod_reg);

        sum4 = {acc_reg[DATA_W-1], acc_reg} + {term_reg[DATA_W-1], term_reg};
        acc_val = tag3_reg.first_k ? term_reg
                                   : sat64({{(64-DATA_W-1){sum4[DATA_W]}}, sum4});
        acc_next = (advance && tag3_reg.valid) ? acc_val : acc_reg;

        load_out = advance && tag3_reg.valid && tag3_reg.last_k;
        out_valid_next = advance ? (tag3_reg.valid && tag3_reg.last_k) : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_mode_reg    <= MODE_ADD;
            rows_a_reg     <= DIM_W'(1);
            inner_size_reg <= DIM_W'(1);
            cols_b_reg     <= DIM_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OP_MODE:    op_mode_reg    <= cfg_data[1:0];
                CFG_ROWS_A:     rows_a_reg     <= cfg_data;
                CFG_INNER_SIZE: inner_size_reg <= cfg_data;
                CFG_COLS_B:     cols_b_reg     <= cfg_data;
                default:        op_mode_reg    <= op_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_i_reg     <= '0;
            cnt_j_reg     <= '0;
            cnt_k_reg     <= '0;
            tag1_reg      <= '0;
            tag2_reg      <= '0;
            tag3_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_i_reg     <= cnt_i_next;
            cnt_j_reg     <= cnt_j_next;
            cnt_k_reg     <= cnt_k_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                tag1_reg <= tag1_next;
                tag2_reg <= tag1_reg;
                tag3_reg <= tag2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg <= prod_next;
            term_reg <= term_next;
        end
        acc_reg <= acc_next;
        if (load_out)
        begin
            out_row_reg <= tag3_reg.row;
            out_col_reg <= tag3_reg.col;
            result_reg  <= acc_val;
            last_reg    <= tag3_reg.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_row      = out_row_reg;
    assign out_col      = out_col_reg;
    assign result_value = result_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

// ===== dv/tb_matrix_add_sub_mul_engine.sv =====
`timescale 1ns / 1ps

module tb_matrix_add_sub_mul_engine;
    import masm_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int DIM           = MAX_DIM_DEF;
    localparam int SETTLE_CYCLES = 20;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_ITEMS  = 70;
    localparam int CALM_ITEMS    = 30;

    typedef struct packed {
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
        logic              last;
    } result_t;

    logic                 clk;
    logic                 rst_n         = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [DIM_W-1:0]     cfg_data      = '0;
    logic                 in_valid      = 1'b0;
    logic [1:0]           operation     = '0;
    logic [IDX_W-1:0]     row_index     = '0;
    logic [IDX_W-1:0]     col_index     = '0;
    logic [DATA_W-1:0]    element_value = '0;
    logic                 out_stall     = 1'b0;
    logic                 in_stall;
    logic                 out_valid;
    logic [IDX_W-1:0]     out_row;
    logic [IDX_W-1:0]     out_col;
    logic [DATA_W-1:0]    result_value;
    logic                 last;

    logic [1:0]        mode_reg  = MODE_ADD;
    logic [DIM_W-1:0]  rows_reg  = 4'd1;
    logic [DIM_W-1:0]  inner_reg = 4'd1;
    logic [DIM_W-1:0]  cols_reg  = 4'd1;
    logic [DATA_W-1:0] a_elems [DIM*DIM];
    logic [DATA_W-1:0] b_elems [DIM*DIM];
    bit                a_known [DIM*DIM];
    bit                b_known [DIM*DIM];

    result_t pending_results[$];
    int      fails      = 0;
    int      cycles     = 0;
    int      items_sent = 0;
    bit      calm       = 1'b0;

    matrix_add_sub_mul_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .row_index    (row_index),
        .col_index    (col_index),
        .element_value(element_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_row      (out_row),
        .out_col      (out_col),
        .result_value (result_value),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int eff_dim(logic [DIM_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > DIM)
            return DIM;
        return int'(v);
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // round to nearest, ties toward plus infinity
    function automatic longint q16_mul(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
        longint p;
        p = longint'(signed'(a)) * longint'(signed'(b)) + 64'sd32768;
        return sat32(p >>> 16);
    endfunction

    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
            3: return ($urandom_range(0, 1) != 0) ? 32'h0001_0000 : 32'hffff_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        int n;
        logic [DIM_W-1:0] v;
        n = $urandom_range(0, 99);
        if (n < 78)
            return DIM_W'($urandom_range(1, 3));
        if (n < 92)
            return DIM_W'($urandom_range(4, 8));
        v = DIM_W'($urandom_range(8, 15));
        return (v == 8) ? '0 : v;
    endfunction

    task automatic predict_run();
        int      nr;
        int      nk;
        int      nc;
        longint  acc;
        result_t res;
        if (mode_reg == MODE_UNUSED)
            return;
        nr = eff_dim(rows_reg);
        nk = eff_dim(inner_reg);
        nc = (mode_reg == MODE_MUL) ? eff_dim(cols_reg) : nk;
        for (int i = 0; i < nr; i++)
        begin
            for (int j = 0; j < nc; j++)
            begin
                if (mode_reg == MODE_MUL)
                begin
                    acc = 0;
                    for (int k = 0; k < nk; k++)
                        acc = sat32(acc + q16_mul(a_elems[i*DIM+k], b_elems[k*DIM+j]));
                end
                else if (mode_reg == MODE_ADD)
                    acc = sat32(longint'(signed'(a_elems[i*DIM+j]))
                                + longint'(signed'(b_elems[i*DIM+j])));
                else
                    acc = sat32(longint'(signed'(a_elems[i*DIM+j]))
                                - longint'(signed'(b_elems[i*DIM+j])));
                res.row   = IDX_W'(i);
                res.col   = IDX_W'(j);
                res.value = acc[DATA_W-1:0];
                res.last  = (i == nr - 1) && (j == nc - 1);
                pending_results.push_back(res);
            end
        end
    endtask

    task automatic send_item(logic [1:0] op, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                             logic [DATA_W-1:0] v);
        if (!calm && $urandom_range(0, 99) < 30)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        operation     <= op;
        row_index     <= r;
        col_index     <= c;
        element_value <= v;
        do @(posedge clk); while (in_stall);
        case (op)
            OP_LOAD_A:
            begin
                a_elems[{r, c}] = v;
                a_known[{r, c}] = 1'b1;
                items_sent++;
            end
            OP_LOAD_B:
            begin
                b_elems[{r, c}] = v;
                b_known[{r, c}] = 1'b1;
                items_sent++;
            end
            OP_COMPUTE:
            begin
                if (mode_reg != MODE_UNUSED)
                    items_sent++;
                predict_run();
            end
            default: ;
        endcase
    endtask

    // drop valid and wait until the block has drained
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_OP_MODE:    mode_reg  = data[1:0];
            CFG_ROWS_A:     rows_reg  = data;
            CFG_INNER_SIZE: inner_reg = data;
            CFG_COLS_B:     cols_reg  = data;
            default: ;
        endcase
    endtask

    task automatic apply_config(logic [1:0] mode, logic [DIM_W-1:0] r, logic [DIM_W-1:0] k,
                                logic [DIM_W-1:0] c);
        settle();
        write_reg(CFG_OP_MODE, {2'($urandom_range(0, 3)), mode});
        write_reg(CFG_ROWS_A, r);
        write_reg(CFG_INNER_SIZE, k);
        write_reg(CFG_COLS_B, c);
        cfg_we <= 1'b0;
    endtask

    task automatic operand_shape(output int ar, output int ac, output int br, output int bc);
        ar = 0;
        ac = 0;
        br = 0;
        bc = 0;
        if (mode_reg == MODE_UNUSED)
            return;
        ar = eff_dim(rows_reg);
        ac = eff_dim(inner_reg);
        br = (mode_reg == MODE_MUL) ? ac : ar;
        bc = (mode_reg == MODE_MUL) ? eff_dim(cols_reg) : ac;
    endtask

    // load every operand entry the next run reads that holds nothing yet, then start the run
    task automatic compute();
        int ar;
        int ac;
        int br;
        int bc;
        operand_shape(ar, ac, br, bc);
        for (int i = 0; i < ar; i++)
            for (int j = 0; j < ac; j++)
                if (!a_known[i*DIM+j])
                    send_item(OP_LOAD_A, IDX_W'(i), IDX_W'(j), rand_value());
        for (int i = 0; i < br; i++)
            for (int j = 0; j < bc; j++)
                if (!b_known[i*DIM+j])
                    send_item(OP_LOAD_B, IDX_W'(i), IDX_W'(j), rand_value());
        send_item(OP_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
    endtask

    task automatic run_phase();
        logic [1:0] mode;
        int ar;
        int ac;
        int br;
        int bc;
        int n;
        mode = ($urandom_range(0, 99) < 92) ? 2'($urandom_range(0, 2)) : MODE_UNUSED;
        apply_config(mode, pick_dim(), pick_dim(), pick_dim());
        operand_shape(ar, ac, br, bc);
        repeat ($urandom_range(1, 3))
        begin
            repeat ($urandom_range(0, 6))
            begin
                n = $urandom_range(0, 99);
                if (n < 35 && ar > 0)
                    send_item(OP_LOAD_A, IDX_W'($urandom_range(0, ar - 1)),
                              IDX_W'($urandom_range(0, ac - 1)), rand_value());
                else if (n < 70 && br > 0)
                    send_item(OP_LOAD_B, IDX_W'($urandom_range(0, br - 1)),
                              IDX_W'($urandom_range(0, bc - 1)), rand_value());
                else if (n < 90)
                    send_item(2'($urandom_range(0, 1)), IDX_W'($urandom), IDX_W'($urandom),
                              rand_value());
                else
                    send_item(OP_UNUSED, IDX_W'($urandom), IDX_W'($urandom), $urandom);
            end
            compute();
            if ($urandom_range(0, 9) == 0)
                send_item(OP_UNUSED, IDX_W'($urandom), IDX_W'($urandom), $urandom);
        end
    endtask

    task automatic test_add_sub_extremes();
        apply_config(MODE_ADD, 4'd2, 4'd2, 4'd1);
        send_item(OP_LOAD_A, 3'd0, 3'd0, 32'h7fff_ffff);
        send_item(OP_LOAD_A, 3'd0, 3'd1, 32'h8000_0000);
        send_item(OP_LOAD_A, 3'd1, 3'd0, 32'h0000_0001);
        send_item(OP_LOAD_A, 3'd1, 3'd1, 32'hffff_ffff);
        send_item(OP_LOAD_B, 3'd0, 3'd0, 32'h7fff_ffff);
        send_item(OP_LOAD_B, 3'd0, 3'd1, 32'h8000_0000);
        send_item(OP_LOAD_B, 3'd1, 3'd0, 32'h7fff_ffff);
        send_item(OP_LOAD_B, 3'd1, 3'd1, 32'h0000_0001);
        compute();
        apply_config(MODE_SUB, 4'd2, 4'd2, 4'd1);
        send_item(OP_LOAD_B, 3'd0, 3'd1, 32'h0000_0001);
        send_item(OP_LOAD_B, 3'd1, 3'd0, 32'h8000_0000);
        compute();
    endtask

    task automatic test_multiply_rounding();
        apply_config(MODE_MUL, 4'd1, 4'd2, 4'd2);
        send_item(OP_LOAD_A, 3'd0, 3'd0, 32'h0000_8000);
        send_item(OP_LOAD_A, 3'd0, 3'd1, 32'hffff_8000);
        send_item(OP_LOAD_B, 3'd0, 3'd0, 32'h0000_0001);
        send_item(OP_LOAD_B, 3'd0, 3'd1, 32'hffff_ffff);
        send_item(OP_LOAD_B, 3'd1, 3'd0, 32'h0000_0001);
        send_item(OP_LOAD_B, 3'd1, 3'd1, 32'h0000_0003);
        compute();
        send_item(OP_LOAD_A, 3'd0, 3'd0, 32'h7fff_ffff);
        send_item(OP_LOAD_A, 3'd0, 3'd1, 32'h7fff_ffff);
        send_item(OP_LOAD_B, 3'd0, 3'd0, 32'h7fff_ffff);
        send_item(OP_LOAD_B, 3'd0, 3'd1, 32'h8000_0000);
        send_item(OP_LOAD_B, 3'd1, 3'd0, 32'h7fff_ffff);
        send_item(OP_LOAD_B, 3'd1, 3'd1, 32'h8000_0000);
        compute();
    endtask

    // zero acts as one, anything above the maximum acts as the maximum
    task automatic test_dim_clamping();
        apply_config(MODE_ADD, 4'd0, 4'd15, 4'd0);
        compute();
        apply_config(MODE_MUL, 4'd9, 4'd15, 4'd8);
        compute();
        apply_config(MODE_SUB, 4'd8, 4'd8, 4'd15);
        compute();
    endtask

    task automatic test_ignored_items();
        apply_config(MODE_UNUSED, 4'd3, 4'd3, 4'd3);
        compute();
        send_item(OP_UNUSED, 3'd0, 3'd0, 32'hdead_beef);
        send_item(OP_UNUSED, 3'd7, 3'd7, 32'h1234_5678);
        apply_config(MODE_ADD, 4'd1, 4'd1, 4'd1);
        compute();
    endtask

    task automatic test_random_traffic();
        int target;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
            run_phase();
    endtask

    task automatic test_no_idle();
        int target;
        target = items_sent + CALM_ITEMS;
        calm = 1'b1;
        while (items_sent < target)
            run_phase();
        settle();
        calm = 1'b0;
    endtask

    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < 30);

    task automatic check_field(string name, logic [DATA_W-1:0] exp, logic [DATA_W-1:0] act);
        if (exp !== act)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp, act);
            fails++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t exp;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result transfer: expected none, actual (%0d,%0d) %h",
                         $time, out_row, out_col, result_value);
                fails++;
            end
            else
            begin
                exp = pending_results.pop_front();
                check_field("out_row", DATA_W'(exp.row), DATA_W'(out_row));
                check_field("out_col", DATA_W'(exp.col), DATA_W'(out_col));
                check_field("result_value", exp.value, result_value);
                check_field("last", DATA_W'(exp.last), DATA_W'(last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_add_sub_extremes();
        test_multiply_rounding();
        test_dim_clamping();
        test_ignored_items();
        test_random_traffic();
        test_no_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/masm_pkg.sv
hdl/masm_ram.sv
hdl/matrix_add_sub_mul_engine.sv
dv/tb_matrix_add_sub_mul_engine.sv
